// ===== hw/rtl/orl_pkg.sv =====
// Shared codes, constants and types for the object record loader.
package orl_pkg;

   localparam int ByteWidth  = 8;
   localparam int AddrWidth  = 16;
   localparam int EventWidth = 2;
   localparam int PhaseWidth = 3;

   localparam logic [PhaseWidth-1:0] PH_MAGIC1  = 3'd0;
   localparam logic [PhaseWidth-1:0] PH_MAGIC2  = 3'd1;
   localparam logic [PhaseWidth-1:0] PH_ADDR_HI = 3'd2;
   localparam logic [PhaseWidth-1:0] PH_ADDR_LO = 3'd3;
   localparam logic [PhaseWidth-1:0] PH_CNT_HI  = 3'd4;
   localparam logic [PhaseWidth-1:0] PH_CNT_LO  = 3'd5;
   localparam logic [PhaseWidth-1:0] PH_DATA    = 3'd6;
   localparam logic [PhaseWidth-1:0] PH_HALT    = 3'd7;

   localparam logic [EventWidth-1:0] EV_WRITE   = 2'd0;
   localparam logic [EventWidth-1:0] EV_DONE    = 2'd1;
   localparam logic [EventWidth-1:0] EV_NOT_OBJ = 2'd2;
   localparam logic [EventWidth-1:0] EV_CORRUPT = 2'd3;

   localparam logic [ByteWidth-1:0] MAGIC_FIRST  = 8'h79;
   localparam logic [ByteWidth-1:0] MAGIC_SECOND = 8'h62;
   localparam logic [ByteWidth-1:0] MAGIC_SEEN   = 8'h01;

   localparam logic [AddrWidth:0] ADDR_LIMIT = 17'h0FFFF;

   typedef struct packed {
      logic                  emit;
      logic [EventWidth-1:0] event_res;
      logic [AddrWidth-1:0]  write_address;
      logic [ByteWidth-1:0]  write_data;
   } step_rsp_type;

endpackage

// ===== hw/rtl/orl_parse.sv =====
// Record parser: phase, header and address state with the per-beat step logic.
module orl_parse (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         step_valid,
   input  logic                         kind,
   input  logic [orl_pkg::ByteWidth-1:0] byte_value,
   output orl_pkg::step_rsp_type        step_rsp
);
   import orl_pkg::*;

   logic [PhaseWidth-1:0] phase_ff, phase_in;
   logic [ByteWidth-1:0]  high_byte_ff, high_byte_in;
   logic [AddrWidth-1:0]  load_address_ff, load_address_in;
   logic [AddrWidth-1:0]  bytes_left_ff, bytes_left_in;
   logic [AddrWidth-1:0]  count;
   logic [AddrWidth:0]    range_sum;
   logic                  eos;

   assign eos       = kind;
   assign count     = {high_byte_ff, byte_value};
   assign range_sum = {1'b0, load_address_ff} + {1'b0, count};

   always_comb begin
      phase_in               = phase_ff;
      high_byte_in           = high_byte_ff;
      load_address_in        = load_address_ff;
      bytes_left_in          = bytes_left_ff;
      step_rsp.emit          = 1'b0;
      step_rsp.event_res     = EV_WRITE;
      step_rsp.write_address = '0;
      step_rsp.write_data    = '0;
      case (phase_ff)
         PH_MAGIC1: begin
            high_byte_in = (!eos && byte_value == MAGIC_FIRST) ? MAGIC_SEEN : '0;
            phase_in     = PH_MAGIC2;
         end
         PH_MAGIC2: begin
            if (high_byte_ff == MAGIC_SEEN && !eos && byte_value == MAGIC_SECOND) begin
               high_byte_in = '0;
               phase_in     = PH_ADDR_HI;
            end else begin
               step_rsp.emit      = 1'b1;
               step_rsp.event_res = EV_NOT_OBJ;
               phase_in           = PH_HALT;
            end
         end
         PH_ADDR_HI: begin
            if (eos) begin
               step_rsp.emit      = 1'b1;
               step_rsp.event_res = EV_DONE;
               phase_in           = PH_HALT;
            end else begin
               high_byte_in = byte_value;
               phase_in     = PH_ADDR_LO;
            end
         end
         PH_ADDR_LO: begin
            if (eos) begin
               step_rsp.emit      = 1'b1;
               step_rsp.event_res = EV_CORRUPT;
               phase_in           = PH_HALT;
            end else begin
               load_address_in = {high_byte_ff, byte_value};
               phase_in        = PH_CNT_HI;
            end
         end
         PH_CNT_HI: begin
            if (eos) begin
               step_rsp.emit      = 1'b1;
               step_rsp.event_res = EV_CORRUPT;
               phase_in           = PH_HALT;
            end else begin
               high_byte_in = byte_value;
               phase_in     = PH_CNT_LO;
            end
         end
         PH_CNT_LO: begin
            if (eos || range_sum > ADDR_LIMIT) begin
               step_rsp.emit      = 1'b1;
               step_rsp.event_res = EV_CORRUPT;
               phase_in           = PH_HALT;
            end else begin
               bytes_left_in = count;
               phase_in      = (count == '0) ? PH_ADDR_HI : PH_DATA;
            end
         end
         PH_DATA: begin
            if (eos) begin
               step_rsp.emit      = 1'b1;
               step_rsp.event_res = EV_CORRUPT;
               phase_in           = PH_HALT;
            end else begin
               step_rsp.emit          = 1'b1;
               step_rsp.event_res     = EV_WRITE;
               step_rsp.write_address = load_address_ff;
               step_rsp.write_data    = byte_value;
               load_address_in        = load_address_ff + 1'b1;
               bytes_left_in          = bytes_left_ff - 1'b1;
               if (bytes_left_ff == {{(AddrWidth-1){1'b0}}, 1'b1}) begin
                  phase_in = PH_ADDR_HI;
               end
            end
         end
         default: begin
            phase_in = PH_HALT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_MAGIC1;
         high_byte_ff    <= '0;
         load_address_ff <= '0;
         bytes_left_ff   <= '0;
      end else if (step_valid) begin
         phase_ff        <= phase_in;
         high_byte_ff    <= high_byte_in;
         load_address_ff <= load_address_in;
         bytes_left_ff   <= bytes_left_in;
      end
   end

   a_halt_silent: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_HALT |-> !step_rsp.emit)
      else $error("result produced while halted");

   a_write_in_data: assert property (@(posedge clock) disable iff (reset)
      step_rsp.emit && step_rsp.event_res == EV_WRITE |-> phase_ff == PH_DATA)
      else $error("write event outside data phase");

   a_data_has_bytes: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_DATA |-> bytes_left_ff != '0)
      else $error("data phase with no bytes left");

   a_data_in_range: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_DATA |->
         ({1'b0, load_address_ff} + {1'b0, bytes_left_ff}) <= (ADDR_LIMIT + 1'b1))
      else $error("record runs past top of memory");

   a_halt_sticks: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_HALT |=> phase_ff == PH_HALT)
      else $error("left halted phase without reset");

endmodule

// ===== hw/rtl/object_record_loader.sv =====
// Object record loader top level: input beat register, parser and result register.
// Takes one object-file byte per cycle when rsp does not stall (tuser high marks end of
// stream) and gives zero or one result per byte: a memory write, or a final load-complete,
// not-an-object or corrupted verdict after which every further byte is taken and dropped
// until reset. Throughput is one beat per cycle while rsp accepts; a result beat is
// registered in turn: the input register captures the byte, the parser step runs on it
// and the result register loads the result. Back-pressure on rsp stalls the parser and
// then req.
module object_record_loader (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] byte_value
   input  logic        req_tuser,   // [0] kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [15:0] write_address, [23:16] write_data
   output logic [1:0]  rsp_tuser    // [1:0] event_res
);
   import orl_pkg::*;

   logic                  in_valid_ff, in_valid_in;
   logic                  in_kind_ff;
   logic [ByteWidth-1:0]  in_byte_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [EventWidth-1:0] rsp_event_ff;
   logic [AddrWidth-1:0]  rsp_addr_ff;
   logic [ByteWidth-1:0]  rsp_data_ff;
   logic                  req_accept;
   logic                  advance;
   step_rsp_type          step_rsp;

   assign advance     = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready  = !in_valid_ff || advance;
   assign req_accept  = req_tvalid && req_tready;
   assign in_valid_in = req_accept || (in_valid_ff && !advance);
   assign rsp_valid_in = advance ? step_rsp.emit : (rsp_valid_ff && !rsp_tready);

   orl_parse u_parse (
      .clock      (clock),
      .reset      (reset),
      .step_valid (advance),
      .kind       (in_kind_ff),
      .byte_value (in_byte_ff),
      .step_rsp   (step_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_kind_ff <= req_tuser;
         in_byte_ff <= req_tdata;
      end
      if (advance && step_rsp.emit) begin
         rsp_event_ff <= step_rsp.event_res;
         rsp_addr_ff  <= step_rsp.write_address;
         rsp_data_ff  <= step_rsp.write_data;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_event_ff;
   assign rsp_tdata  = {rsp_data_ff, rsp_addr_ff};

   a_no_step_on_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_tready |-> !advance)
      else $error("parser stepped while result beat stalled");

   a_step_needs_beat: assert property (@(posedge clock) disable iff (reset)
      advance |-> in_valid_ff)
      else $error("parser stepped without an input beat");

   a_hold_unstepped: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_byte_ff) && $stable(in_kind_ff))
      else $error("input beat lost before parser step");

endmodule

// ===== tb/orl_load_checker.sv =====
// Load-event predictor and result comparator for the object record loader.
module orl_load_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] byte_value
   input  logic        req_tuser,   // [0] kind
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [23:0] rsp_tdata,   // [15:0] write_address, [23:16] write_data
   input  logic [1:0]  rsp_tuser,   // [1:0] event_res
   output int unsigned error_count,
   output int unsigned pending_count
);
   import orl_pkg::*;

   typedef struct packed {
      logic [EventWidth-1:0] res;
      logic [AddrWidth-1:0]  address;
      logic [ByteWidth-1:0]  data;
   } load_event_type;

   load_event_type              load_events_q[$];
   logic [PhaseWidth-1:0]       parse_phase;
   logic [ByteWidth-1:0]        held_byte;
   logic [AddrWidth-1:0]        next_address;
   logic [AddrWidth-1:0]        data_left;

   function automatic bit parse_beat(input logic end_mark, input logic [ByteWidth-1:0] value,
                                     output load_event_type outcome);
      logic [AddrWidth-1:0] byte_count;
      outcome = '0;
      case (parse_phase)
         PH_MAGIC1: begin
            held_byte   = (!end_mark && value == MAGIC_FIRST) ? MAGIC_SEEN : '0;
            parse_phase = PH_MAGIC2;
         end
         PH_MAGIC2: begin
            if (held_byte == MAGIC_SEEN && !end_mark && value == MAGIC_SECOND) begin
               held_byte   = '0;
               parse_phase = PH_ADDR_HI;
            end else begin
               outcome.res = EV_NOT_OBJ;
               parse_phase = PH_HALT;
               return 1'b1;
            end
         end
         PH_ADDR_HI: begin
            if (end_mark) begin
               outcome.res = EV_DONE;
               parse_phase = PH_HALT;
               return 1'b1;
            end
            held_byte   = value;
            parse_phase = PH_ADDR_LO;
         end
         PH_ADDR_LO, PH_CNT_HI, PH_CNT_LO, PH_DATA: begin
            if (end_mark) begin
               outcome.res = EV_CORRUPT;
               parse_phase = PH_HALT;
               return 1'b1;
            end
            case (parse_phase)
               PH_ADDR_LO: begin
                  next_address = {held_byte, value};
                  parse_phase  = PH_CNT_HI;
               end
               PH_CNT_HI: begin
                  held_byte   = value;
                  parse_phase = PH_CNT_LO;
               end
               PH_CNT_LO: begin
                  byte_count = {held_byte, value};
                  if ({1'b0, next_address} + {1'b0, byte_count} > ADDR_LIMIT) begin
                     outcome.res = EV_CORRUPT;
                     parse_phase = PH_HALT;
                     return 1'b1;
                  end
                  data_left   = byte_count;
                  parse_phase = (byte_count == '0) ? PH_ADDR_HI : PH_DATA;
               end
               default: begin
                  outcome.res     = EV_WRITE;
                  outcome.address = next_address;
                  outcome.data    = value;
                  next_address    = next_address + 1'b1;
                  data_left       = data_left - 1'b1;
                  if (data_left == '0)
                     parse_phase = PH_ADDR_HI;
                  return 1'b1;
               end
            endcase
         end
         default: ;
      endcase
      return 1'b0;
   endfunction

   always @(posedge clock) begin
      load_event_type predicted;
      load_event_type oldest;
      if (reset) begin
         parse_phase  = PH_MAGIC1;
         held_byte    = '0;
         next_address = '0;
         data_left    = '0;
         load_events_q.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (load_events_q.size() == 0) begin
               $display("%0t: unexpected result beat event %0d address %h data %h",
                        $time, rsp_tuser, rsp_tdata[15:0], rsp_tdata[23:16]);
               error_count++;
            end else begin
               oldest = load_events_q.pop_front();
               if (rsp_tuser !== oldest.res) begin
                  $display("%0t: event expected %0d actual %0d", $time, oldest.res, rsp_tuser);
                  error_count++;
               end
               if (rsp_tdata[15:0] !== oldest.address) begin
                  $display("%0t: write_address expected %h actual %h",
                           $time, oldest.address, rsp_tdata[15:0]);
                  error_count++;
               end
               if (rsp_tdata[23:16] !== oldest.data) begin
                  $display("%0t: write_data expected %h actual %h",
                           $time, oldest.data, rsp_tdata[23:16]);
                  error_count++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            if (parse_beat(req_tuser, req_tdata, predicted))
               load_events_q.push_back(predicted);
         end
      end
      pending_count = load_events_q.size();
   end

endmodule

// ===== tb/tb_object_record_loader.sv =====
// Stimulus, clocking and verdict for the object record loader testbench.
module tb_object_record_loader;
   import orl_pkg::*;

   localparam logic        KIND_BYTE      = 1'b0;
   localparam logic        KIND_END       = 1'b1;
   localparam int unsigned STREAM_BEATS   = 850;
   localparam int unsigned NOISE_BEATS    = 40;
   localparam int unsigned DRAIN_CYCLES   = 20;
   localparam int unsigned WATCHDOG_LIMIT = 1000;

   typedef enum int { PICK_GOOD, PICK_WRONG, PICK_END } magic_pick_type;
   typedef enum int { END_CLEAN, END_CUT_HEADER, END_OVERFLOW, END_CUT_DATA } stream_end_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;   // [7:0] byte_value
   logic        req_tuser = 1'b0; // [0] kind
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;        // [15:0] write_address, [23:16] write_data
   logic [1:0]  rsp_tuser;        // [1:0] event_res

   int unsigned error_count;
   int unsigned pending_count;
   int unsigned beats_sent = 0;
   int unsigned idle_cycles = 0;
   bit          no_idle = 1'b0;

   object_record_loader i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   orl_load_checker i_load_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .error_count   (error_count),
      .pending_count (pending_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("tb_object_record_loader: errors");
         $finish;
      end
   end

   function automatic int unsigned draw_gap();
      return no_idle ? 0 : $urandom_range(0, 9);
   endfunction

   task automatic send_beat(input logic kind, input logic [7:0] value);
      int unsigned gap;
      gap = draw_gap();
      if (gap != 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = kind;
      req_tdata  = value;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      beats_sent++;
   endtask

   task automatic send_word(input logic [15:0] value);
      send_beat(KIND_BYTE, value[15:8]);
      send_beat(KIND_BYTE, value[7:0]);
   endtask

   task automatic send_data(input int unsigned count);
      repeat (count) send_beat(KIND_BYTE, 8'($urandom_range(0, 255)));
   endtask

   task automatic send_magic_slot(input magic_pick_type pick, input logic [7:0] good_value);
      logic [7:0] wrong;
      case (pick)
         PICK_GOOD:  send_beat(KIND_BYTE, good_value);
         PICK_WRONG: begin
            do wrong = 8'($urandom_range(0, 255)); while (wrong == good_value);
            send_beat(KIND_BYTE, wrong);
         end
         default:    send_beat(KIND_END, 8'($urandom_range(0, 255)));
      endcase
   endtask

   // receiver: before each result beat, hold rsp_tready low for a gap drawn by draw_gap
   initial begin
      int unsigned stall;
      @(negedge clock);
      forever begin
         stall = draw_gap();
         if (stall != 0) begin
            rsp_tready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready = 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         @(negedge clock);
      end
   end

   initial begin
      magic_pick_type first_pick;
      magic_pick_type second_pick;
      stream_end_type ending;
      int             address;
      int             count;
      int             cut;
      bit             drained = 1'b0;

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      if ($urandom_range(0, 4) == 0) begin
         first_pick  = magic_pick_type'($urandom_range(0, 2));
         second_pick = magic_pick_type'($urandom_range(0, 2));
         if (first_pick == PICK_GOOD && second_pick == PICK_GOOD)
            second_pick = PICK_WRONG;
         send_magic_slot(first_pick, MAGIC_FIRST);
         send_magic_slot(second_pick, MAGIC_SECOND);
         req_tvalid = 1'b0;
         while (pending_count != 0) @(negedge clock);
      end else begin
         send_beat(KIND_BYTE, MAGIC_FIRST);
         send_beat(KIND_BYTE, MAGIC_SECOND);
         // lowest address, data extremes
         send_word(16'h0000);
         send_word(16'h0002);
         send_beat(KIND_BYTE, 8'h00);
         send_beat(KIND_BYTE, 8'hFF);
         // empty record at the top of memory
         send_word(16'hFFFF);
         send_word(16'h0000);
         // record whose address plus count reaches ADDR_LIMIT exactly
         send_word(16'hFFFE);
         send_word(16'h0001);
         send_beat(KIND_BYTE, 8'hA5);
         send_word(16'h8001);
         send_word(16'h0001);
         send_beat(KIND_BYTE, 8'h5A);

         while (beats_sent < STREAM_BEATS) begin
            if ($urandom_range(0, 15) == 0)
               no_idle = !no_idle;
            case ($urandom_range(0, 15))
               0:       count = 0;
               15:      count = $urandom_range(13, 64);
               default: count = $urandom_range(1, 12);
            endcase
            if ($urandom_range(0, 7) == 0)
               address = 'hFFFF - count;
            else
               address = $urandom_range(0, 'hFFFF - count);
            send_word(address[15:0]);
            send_word(count[15:0]);
            send_data(count);
            if (!drained && beats_sent >= STREAM_BEATS / 2) begin
               req_tvalid = 1'b0;
               while (pending_count != 0) @(negedge clock);
               drained = 1'b1;
            end
         end

         no_idle = 1'b0;
         ending = stream_end_type'($urandom_range(0, 3));
         case (ending)
            END_CLEAN: ;
            END_CUT_HEADER: begin
               cut = $urandom_range(1, 3);
               if (cut >= 2)
                  send_word(16'($urandom_range(0, 'hFFFF)));
               else
                  send_beat(KIND_BYTE, 8'($urandom_range(0, 255)));
               if (cut == 3)
                  send_beat(KIND_BYTE, 8'($urandom_range(0, 255)));
            end
            END_OVERFLOW: begin
               address = $urandom_range(1, 'hFFFF);
               count   = $urandom_range('h10000 - address, 'hFFFF);
               send_word(address[15:0]);
               send_word(count[15:0]);
            end
            default: begin
               count   = $urandom_range(2, 8);
               address = $urandom_range(0, 'hFFFF - count);
               send_word(address[15:0]);
               send_word(count[15:0]);
               send_data($urandom_range(1, count - 1));
            end
         endcase
         if (ending == END_OVERFLOW)
            send_beat(KIND_BYTE, 8'($urandom_range(0, 255)));
         else
            send_beat(KIND_END, 8'($urandom_range(0, 255)));
      end

      // halted: every further beat is dropped
      repeat (NOISE_BEATS) send_beat(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
      while (beats_sent < STREAM_BEATS)
         send_beat(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));

      req_tvalid = 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (error_count == 0 && pending_count == 0)
         $display("tb_object_record_loader: clean");
      else
         $display("tb_object_record_loader: errors");
      $finish;
   end

endmodule

// ===== object_record_loader.f =====
hw/rtl/orl_pkg.sv
hw/rtl/orl_parse.sv
hw/rtl/object_record_loader.sv
tb/orl_load_checker.sv
tb/tb_object_record_loader.sv
